// ===== src/tbw_pkg.sv =====
// Package for the triangle barycentric weights core: field widths, default
// parameter values and the request and control struct types.
// Depends on nothing; every module of the block imports it.
package tbw_pkg;

    localparam int VERT_W          = 16;
    localparam int PIX_W           = 12;
    localparam int WEIGHT_W        = 32;
    localparam int DIFF_W          = VERT_W + 1;
    localparam int DET_W           = 2 * DIFF_W + 1;
    localparam int COORD_FRAC_DEF  = 4;
    localparam int WEIGHT_FRAC_DEF = 16;

    typedef struct packed {
        logic signed [VERT_W-1:0] vert0_x;
        logic signed [VERT_W-1:0] vert0_y;
        logic signed [VERT_W-1:0] vert1_x;
        logic signed [VERT_W-1:0] vert1_y;
        logic signed [VERT_W-1:0] vert2_x;
        logic signed [VERT_W-1:0] vert2_y;
        logic [PIX_W-1:0]         pixel_x;
        logic [PIX_W-1:0]         pixel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_a;
        logic signed [WEIGHT_W-1:0] weight_b;
        logic signed [WEIGHT_W-1:0] weight_c;
        logic                       degenerate;
        logic                       saturated;
    } t_out_item;

    // Control that travels beside each request through the pipeline.
    typedef struct packed {
        logic valid;
        logic degenerate;
        logic neg_a;
        logic neg_b;
    } t_div_ctl;

endpackage

// ===== src/triangle_barycentric_weights_core.sv =====
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_item (t_in_item)
// result    out        o_valid / i_stall    o_item (t_out_item)
//
// One request enters per cycle while o_stall is low. Each request passes
// through 4 + (NUM_W + WEIGHT_FRAC_BITS + 1) + 2 + 1 register stages (setup,
// divider, finishing, output), 60 at the default settings, most of them in the
// one-bit-per-stage divider.
// Reset is synchronous and clears only the valid bits and the control structs
// beside them. A stalled result is held in the output register and the next
// one in a skid register; the pipeline freezes only once both are full.
// Top level of the triangle barycentric weights core: signs, third weight,
// saturation and output buffering. Depends on tbw_pkg, tbw_setup, tbw_div.
module triangle_barycentric_weights_core #(
    parameter int COORD_FRAC_BITS  = tbw_pkg::COORD_FRAC_DEF,
    parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tbw_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output tbw_pkg::t_out_item  o_item
);
    import tbw_pkg::*;

    localparam int PXW   = PIX_W + COORD_FRAC_BITS;
    localparam int DXW   = ((PXW > VERT_W) ? PXW : VERT_W) + 2;
    localparam int NUM_W = DIFF_W + DXW + 1;
    localparam int DVW   = NUM_W + WEIGHT_FRAC_BITS;
    localparam int QW    = DVW + 1;
    localparam int CW    = DVW + 3;

    localparam logic signed [CW-1:0] ONE    = CW'(1) << WEIGHT_FRAC_BITS;
    localparam logic signed [CW-1:0] W_MAX  = CW'({1'b0, {(WEIGHT_W-1){1'b1}}});
    localparam logic signed [CW-1:0] W_MIN  = -W_MAX - CW'(1);

    logic               n_en;
    t_div_ctl           n_setup_ctl, n_div_ctl;
    logic [DET_W-1:0]   n_det_mag;
    logic [NUM_W-1:0]   n_num_a, n_num_b;
    logic [DVW-1:0]     n_quo_a, n_quo_b;

    t_div_ctl                r1_ctl, r2_ctl;
    logic signed [QW-1:0]    r1_q0, r1_q1;
    logic signed [CW-1:0]    r2_q0, r2_q1, r2_q2;

    t_out_item  n_res, r_out, r_skid;
    logic       r_out_valid, r_skid_valid;
    logic       n_out_free;
    logic       n_hi0, n_lo0, n_hi1, n_lo1, n_hi2, n_lo2;

    // The pipeline moves unless the skid register already holds a result.
    assign n_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    tbw_setup #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .NUM_W           (NUM_W)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (n_en),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_ctl       (n_setup_ctl),
        .o_det_mag   (n_det_mag),
        .o_num_a_mag (n_num_a),
        .o_num_b_mag (n_num_b)
    );

    tbw_div #(
        .NUM_W  (NUM_W),
        .FRAC_W (WEIGHT_FRAC_BITS),
        .DEN_W  (DET_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_ctl   (n_setup_ctl),
        .i_den   (n_det_mag),
        .i_num_a (n_num_a),
        .i_num_b (n_num_b),
        .o_ctl   (n_div_ctl),
        .o_quo_a (n_quo_a),
        .o_quo_b (n_quo_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
        end else if (n_en) begin
            r1_ctl <= n_div_ctl;
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_q0 <= n_div_ctl.neg_a ? -$signed({1'b0, n_quo_a}) : $signed({1'b0, n_quo_a});
            r1_q1 <= n_div_ctl.neg_b ? -$signed({1'b0, n_quo_b}) : $signed({1'b0, n_quo_b});
            r2_q0 <= CW'(r1_q0);
            r2_q1 <= CW'(r1_q1);
            r2_q2 <= ONE - CW'(r1_q0) - CW'(r1_q1);
        end
    end

    // Saturation to the 32-bit weight range; a degenerate triangle gives
    // zero weights and no saturation flag.
    assign n_hi0 = r2_q0 > W_MAX;
    assign n_lo0 = r2_q0 < W_MIN;
    assign n_hi1 = r2_q1 > W_MAX;
    assign n_lo1 = r2_q1 < W_MIN;
    assign n_hi2 = r2_q2 > W_MAX;
    assign n_lo2 = r2_q2 < W_MIN;

    always_comb begin
        n_res = '0;
        n_res.degenerate = r2_ctl.degenerate;
        if (!r2_ctl.degenerate) begin
            n_res.weight_a  = n_hi0 ? WEIGHT_W'(W_MAX) : (n_lo0 ? WEIGHT_W'(W_MIN)
                                                                : WEIGHT_W'(r2_q0));
            n_res.weight_b  = n_hi1 ? WEIGHT_W'(W_MAX) : (n_lo1 ? WEIGHT_W'(W_MIN)
                                                                : WEIGHT_W'(r2_q1));
            n_res.weight_c  = n_hi2 ? WEIGHT_W'(W_MAX) : (n_lo2 ? WEIGHT_W'(W_MIN)
                                                                : WEIGHT_W'(r2_q2));
            n_res.saturated = n_hi0 | n_lo0 | n_hi1 | n_lo1 | n_hi2 | n_lo2;
        end
    end

    assign n_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r2_ctl.valid;
            end
        end else if (r2_ctl.valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (!r_skid_valid) begin
            r_skid <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== src/tbw_setup.sv =====
// Front end of the barycentric weights core: edge differences, products,
// determinant and numerators, then magnitudes and quotient signs.
// Depends on tbw_pkg.
module tbw_setup #(
    parameter int COORD_FRAC_BITS = tbw_pkg::COORD_FRAC_DEF,
    parameter int NUM_W           = 36
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  tbw_pkg::t_in_item           i_item,
    output tbw_pkg::t_div_ctl           o_ctl,
    output logic [tbw_pkg::DET_W-1:0]   o_det_mag,
    output logic [NUM_W-1:0]            o_num_a_mag,
    output logic [NUM_W-1:0]            o_num_b_mag
);
    import tbw_pkg::*;

    localparam int PXW = PIX_W + COORD_FRAC_BITS;
    localparam int DXW = ((PXW > VERT_W) ? PXW : VERT_W) + 2;
    localparam int PRW = DIFF_W + DXW;
    localparam int DPW = 2 * DIFF_W;

    // Stage 1: differences
    logic                      r1_valid;
    logic signed [DIFF_W-1:0]  r1_a00, r1_a01, r1_a10, r1_a11, r1_d0, r1_d1;
    logic signed [DXW-1:0]     r1_dx, r1_dy;
    logic [PXW-1:0]            n_px, n_py;

    // Stage 2: products
    logic                      r2_valid;
    logic signed [DPW-1:0]     r2_pd0, r2_pd1;
    logic signed [PRW-1:0]     r2_p00, r2_p01, r2_p10, r2_p11;

    // Stage 3: sums
    logic                      r3_valid;
    logic signed [DET_W-1:0]   r3_det;
    logic signed [NUM_W-1:0]   r3_n0, r3_n1;

    // Stage 4: magnitudes and signs
    t_div_ctl                  r4_ctl;
    logic [DET_W-1:0]          r4_det_mag;
    logic [NUM_W-1:0]          r4_n0_mag, r4_n1_mag;

    assign n_px = PXW'(i_item.pixel_x) << COORD_FRAC_BITS;
    assign n_py = PXW'(i_item.pixel_y) << COORD_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_ctl   <= '0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_ctl.valid      <= r3_valid;
            r4_ctl.degenerate <= (r3_det == '0);
            r4_ctl.neg_a      <= r3_n0[NUM_W-1] ^ r3_det[DET_W-1];
            r4_ctl.neg_b      <= r3_n1[NUM_W-1] ^ r3_det[DET_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a00 <= DIFF_W'($signed(i_item.vert1_y)) - DIFF_W'($signed(i_item.vert2_y));
            r1_a01 <= DIFF_W'($signed(i_item.vert2_x)) - DIFF_W'($signed(i_item.vert1_x));
            r1_a10 <= DIFF_W'($signed(i_item.vert2_y)) - DIFF_W'($signed(i_item.vert0_y));
            r1_a11 <= DIFF_W'($signed(i_item.vert0_x)) - DIFF_W'($signed(i_item.vert2_x));
            r1_d0  <= DIFF_W'($signed(i_item.vert0_x)) - DIFF_W'($signed(i_item.vert2_x));
            r1_d1  <= DIFF_W'($signed(i_item.vert0_y)) - DIFF_W'($signed(i_item.vert2_y));
            r1_dx  <= DXW'($signed({1'b0, n_px})) - DXW'($signed(i_item.vert2_x));
            r1_dy  <= DXW'($signed({1'b0, n_py})) - DXW'($signed(i_item.vert2_y));

            r2_pd0 <= DPW'(r1_a00) * DPW'(r1_d0);
            r2_pd1 <= DPW'(r1_a01) * DPW'(r1_d1);
            r2_p00 <= PRW'(r1_a00) * PRW'(r1_dx);
            r2_p01 <= PRW'(r1_a01) * PRW'(r1_dy);
            r2_p10 <= PRW'(r1_a10) * PRW'(r1_dx);
            r2_p11 <= PRW'(r1_a11) * PRW'(r1_dy);

            r3_det <= DET_W'(r2_pd0) + DET_W'(r2_pd1);
            r3_n0  <= NUM_W'(r2_p00) + NUM_W'(r2_p01);
            r3_n1  <= NUM_W'(r2_p10) + NUM_W'(r2_p11);

            // The most negative value negates to its own bit pattern, which
            // reads correctly as an unsigned magnitude.
            r4_det_mag <= r3_det[DET_W-1] ? DET_W'(-r3_det) : DET_W'(r3_det);
            r4_n0_mag  <= r3_n0[NUM_W-1] ? NUM_W'(-r3_n0) : NUM_W'(r3_n0);
            r4_n1_mag  <= r3_n1[NUM_W-1] ? NUM_W'(-r3_n1) : NUM_W'(r3_n1);
        end
    end

    assign o_ctl       = r4_ctl;
    assign o_det_mag   = r4_det_mag;
    assign o_num_a_mag = r4_n0_mag;
    assign o_num_b_mag = r4_n1_mag;

endmodule

// ===== src/tbw_div.sv =====
// Pipelined restoring divider for the two weight numerators, one quotient
// bit per stage, both lanes sharing the divisor. Depends on tbw_pkg.
module tbw_div #(
    parameter int NUM_W  = 36,
    parameter int FRAC_W = tbw_pkg::WEIGHT_FRAC_DEF,
    parameter int DEN_W  = tbw_pkg::DET_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  tbw_pkg::t_div_ctl         i_ctl,
    input  logic [DEN_W-1:0]          i_den,
    input  logic [NUM_W-1:0]          i_num_a,
    input  logic [NUM_W-1:0]          i_num_b,
    output tbw_pkg::t_div_ctl         o_ctl,
    output logic [NUM_W+FRAC_W-1:0]   o_quo_a,
    output logic [NUM_W+FRAC_W-1:0]   o_quo_b
);
    import tbw_pkg::*;

    localparam int DVW = NUM_W + FRAC_W;

    t_div_ctl          r_ctl   [0:DVW];
    logic [DEN_W-1:0]  r_den   [0:DVW];
    logic [DVW-1:0]    r_acc_a [0:DVW];
    logic [DVW-1:0]    r_acc_b [0:DVW];
    logic [DEN_W-1:0]  r_rem_a [0:DVW];
    logic [DEN_W-1:0]  r_rem_b [0:DVW];

    // Stage 0 loads the scaled dividends; each accumulator shifts dividend
    // bits out at the top and quotient bits in at the bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]   <= i_den;
            r_acc_a[0] <= {i_num_a, {FRAC_W{1'b0}}};
            r_acc_b[0] <= {i_num_b, {FRAC_W{1'b0}}};
            r_rem_a[0] <= '0;
            r_rem_b[0] <= '0;
        end
    end

    for (genvar k = 0; k < DVW; k++) begin : g_step
        logic [DEN_W:0] n_try_a, n_try_b;
        logic           n_ge_a, n_ge_b;

        assign n_try_a = {r_rem_a[k], r_acc_a[k][DVW-1]};
        assign n_try_b = {r_rem_b[k], r_acc_b[k][DVW-1]};
        assign n_ge_a  = n_try_a >= {1'b0, r_den[k]};
        assign n_ge_b  = n_try_b >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1] <= '0;
            end else if (i_en) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1]   <= r_den[k];
                r_rem_a[k+1] <= n_ge_a ? DEN_W'(n_try_a - {1'b0, r_den[k]}) : DEN_W'(n_try_a);
                r_rem_b[k+1] <= n_ge_b ? DEN_W'(n_try_b - {1'b0, r_den[k]}) : DEN_W'(n_try_b);
                r_acc_a[k+1] <= {r_acc_a[k][DVW-2:0], n_ge_a};
                r_acc_b[k+1] <= {r_acc_b[k][DVW-2:0], n_ge_b};
            end
        end
    end

    assign o_ctl   = r_ctl[DVW];
    assign o_quo_a = r_acc_a[DVW];
    assign o_quo_b = r_acc_b[DVW];

endmodule

// ===== verif/tb_triangle_barycentric_weights_core.sv =====
// Testbench for the triangle barycentric weights core: directed and random
// requests against a scoreboard that predicts each result in fixed point.
// Depends on tbw_pkg and triangle_barycentric_weights_core.
module tb_triangle_barycentric_weights_core;
    import tbw_pkg::*;

    localparam int CFB = COORD_FRAC_DEF;
    localparam int WFB = WEIGHT_FRAC_DEF;
    localparam int N_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    class weight_scoreboard;
        t_out_item pending[$];
        int errors;

        function void note_request(t_in_item it);
            pending.push_back(predict_weights(it));
        endfunction

        task check_result(t_out_item got);
            t_out_item exp_item;
            if (pending.size() == 0) begin
                report_mismatch("result with no request waiting");
                return;
            end
            exp_item = pending.pop_front();
            if (got.weight_a !== exp_item.weight_a)
                report_mismatch($sformatf("weight_a got %0d exp %0d",
                    got.weight_a, exp_item.weight_a));
            if (got.weight_b !== exp_item.weight_b)
                report_mismatch($sformatf("weight_b got %0d exp %0d",
                    got.weight_b, exp_item.weight_b));
            if (got.weight_c !== exp_item.weight_c)
                report_mismatch($sformatf("weight_c got %0d exp %0d",
                    got.weight_c, exp_item.weight_c));
            if (got.degenerate !== exp_item.degenerate)
                report_mismatch($sformatf("degenerate got %b exp %b",
                    got.degenerate, exp_item.degenerate));
            if (got.saturated !== exp_item.saturated)
                report_mismatch($sformatf("saturated got %b exp %b",
                    got.saturated, exp_item.saturated));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask
    endclass

    // Truncating division of n * 2^WFB by d, on magnitudes.
    function automatic longint scaled_quotient(longint n, longint d);
        longint unsigned nm, dm, q;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = (nm << WFB) / dm;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clip32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_out_item predict_weights(t_in_item it);
        longint x0, y0, x1, y1, x2, y2, px, py, det, n0, n1, q0, q1, q2;
        t_out_item r;
        logic sat;
        x0 = it.vert0_x; y0 = it.vert0_y;
        x1 = it.vert1_x; y1 = it.vert1_y;
        x2 = it.vert2_x; y2 = it.vert2_y;
        px = longint'(it.pixel_x) << CFB;
        py = longint'(it.pixel_y) << CFB;
        det = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
        r = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        n0 = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
        n1 = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
        q0 = scaled_quotient(n0, det);
        q1 = scaled_quotient(n1, det);
        q2 = (longint'(1) << WFB) - q0 - q1;
        sat = 1'b0;
        r.weight_a = clip32(q0, sat);
        r.weight_b = clip32(q1, sat);
        r.weight_c = clip32(q2, sat);
        r.saturated = sat;
        return r;
    endfunction

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    t_in_item i_item = '0;
    t_out_item o_item;
    longint cycles = 0;
    weight_scoreboard sb;

    triangle_barycentric_weights_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_triangle_barycentric_weights_core: FAIL");
            $finish;
        end
    end

    // Receiver stalls in its own pattern: quiet, light and heavy phases.
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    int gap_left = 0;
    int burst_left = 0;

    // Drives one request; on entry we are at a falling edge. Valid is left
    // high on return and is dropped by the next gap or by the caller.
    task automatic send_request(t_in_item it);
        while (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left--;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(it);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return $signed(16'($urandom_range(0, 4095))) <<< CFB;
            2: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 255)) << CFB;
        endcase
    endfunction

    function automatic t_in_item rand_request();
        t_in_item it;
        it.vert0_x = rand_coord(); it.vert0_y = rand_coord();
        it.vert1_x = rand_coord(); it.vert1_y = rand_coord();
        it.vert2_x = rand_coord(); it.vert2_y = rand_coord();
        it.pixel_x = 12'($urandom()); it.pixel_y = 12'($urandom());
        if ($urandom_range(0, 3) == 0) begin
            it.pixel_x = 12'((it.vert0_x >>> CFB) + $urandom_range(0, 8));
            it.pixel_y = 12'((it.vert0_y >>> CFB) + $urandom_range(0, 8));
        end
        case ($urandom_range(0, 19))
            0: begin // collinear, so the determinant is zero
                it.vert1_x = it.vert0_x; it.vert1_y = it.vert0_y;
            end
            1: begin // tiny triangle: weights far outside range
                it.vert1_x = 16'(it.vert0_x + 16'sd1); it.vert1_y = it.vert0_y;
                it.vert2_x = it.vert0_x; it.vert2_y = 16'(it.vert0_y + 16'sd1);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in_item make_tri(int x0, int y0, int x1, int y1,
                                          int x2, int y2, int px, int py);
        t_in_item it;
        it.vert0_x = 16'(x0); it.vert0_y = 16'(y0);
        it.vert1_x = 16'(x1); it.vert1_y = 16'(y1);
        it.vert2_x = 16'(x2); it.vert2_y = 16'(y2);
        it.pixel_x = 12'(px); it.pixel_y = 12'(py);
        return it;
    endfunction

    initial begin
        t_in_item dir[$];
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        dir.push_back(make_tri(0, 0, 160, 0, 0, 160, 2, 3));
        dir.push_back(make_tri(0, 0, 160, 0, 0, 160, 0, 0));
        dir.push_back(make_tri(0, 0, 160, 0, 0, 160, 10, 0));
        dir.push_back(make_tri(16, 16, 16, 16, 48, 48, 5, 5));
        dir.push_back(make_tri(0, 0, 16, 16, 32, 32, 7, 1));
        dir.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
        dir.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768,
                               4095, 4095));
        dir.push_back(make_tri(0, 0, 1, 0, 0, 1, 4095, 4095));
        dir.push_back(make_tri(0, 0, 1, 0, 0, 1, 4095, 0));
        dir.push_back(make_tri(0, 0, 0, 1, 1, 0, 4095, 4095));
        dir.push_back(make_tri(-32768, 0, 0, 0, 0, 1, 0, 4095));
        dir.push_back(make_tri(-1, -1, -1, -1, -1, -1, 0, 0));
        dir.push_back(make_tri(32767, -32768, 0, 0, -32768, 32767, 2048, 2048));
        dir.push_back(make_tri(0, 0, 160, 0, 0, -160, 3, 4095));
        dir.push_back(make_tri(100, 200, 300, -50, -400, 17, 1, 2));
        dir.push_back(make_tri(-32768, -32768, -32767, -32768, -32768, -32767,
                               4095, 4095));
        foreach (dir[k]) send_request(dir[k]);
        repeat (N_RANDOM) send_request(rand_request());
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_triangle_barycentric_weights_core: PASS");
        else
            $display("tb_triangle_barycentric_weights_core: FAIL");
        $finish;
    end
endmodule
